FILE: rtl/core/skid_steer_motor_mixer_assert.svh
// Assertion macros for the skid-steer motor mixer.
`ifndef SKID_STEER_MOTOR_MIXER_ASSERT_SVH
`define SKID_STEER_MOTOR_MIXER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SSMM_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SSMM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ssmm_pkg.sv
// Shared types, constants and helpers of the skid-steer motor mixer.
package ssmm_pkg;

    localparam int SPD_W     = 16;
    localparam int CMD_W     = SPD_W + 1;
    localparam int DUTY_W    = 15;
    localparam int GAIN_W    = 10;
    localparam int FRAC_W    = 8;
    localparam int FULL_W    = CMD_W + GAIN_W;
    localparam int SRC_W     = FULL_W - FRAC_W;
    localparam int MOTOR_W   = 2;
    localparam int STEP_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam int S_TDATA_W = 2 * SPD_W;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    localparam logic [DUTY_W-1:0] DEADZONE_RST  = 15'd400;
    localparam logic [DUTY_W-1:0] MAX_DUTY_RST  = 15'd2000;
    localparam logic [GAIN_W-1:0] REAR_GAIN_RST = 10'd333;

    localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REAR_GAIN = 2'd2;

    localparam logic [MOTOR_W-1:0] MOTOR_LEFT_F  = 2'd0;
    localparam logic [MOTOR_W-1:0] MOTOR_RIGHT_F = 2'd1;
    localparam logic [MOTOR_W-1:0] MOTOR_RIGHT_R = 2'd2;
    localparam logic [MOTOR_W-1:0] MOTOR_REAR    = 2'd3;
    localparam int                 N_MOTORS      = 4;

    localparam logic [STEP_W-1:0] STEP_LAST = 2'd3;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } dir_t;

    // One tick as queued between front and back end.
    typedef struct packed {
        logic signed [CMD_W-1:0]  diff;
        logic signed [CMD_W-1:0]  sum;
        logic        [FULL_W-1:0] rear_full;
    } tick_t;

    typedef struct packed {
        logic [MOTOR_W-1:0] motor_index;
        logic [DUTY_W-1:0]  fwd_duty;
        logic [DUTY_W-1:0]  rev_duty;
        logic               dir_pin;
        logic               is_brake;
        logic               in_deadzone;
        logic               last;
    } out_item_t;

    // Motor service order 0, 3, 1, 2.
    function automatic logic [MOTOR_W-1:0] motor_of_step(input logic [STEP_W-1:0] step);
        logic [MOTOR_W-1:0] m;
        case (step)
            2'd0:    m = MOTOR_LEFT_F;
            2'd1:    m = MOTOR_REAR;
            2'd2:    m = MOTOR_RIGHT_F;
            default: m = MOTOR_RIGHT_R;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/core/ssmm_front.sv
// Front end: takes a tick, mixes speed and yaw, forms the rear gain product.
module ssmm_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic signed [ssmm_pkg::SPD_W-1:0] fwd_speed,
    input  logic signed [ssmm_pkg::SPD_W-1:0] yaw_term,
    input  logic                              run_enable,
    input  logic [ssmm_pkg::GAIN_W-1:0]       rear_gain_q8,
    input  logic                              q_full,
    output logic                              q_push,
    output ssmm_pkg::tick_t                   q_wdata
);
    import ssmm_pkg::*;

    logic                    st_valid_reg;
    logic                    st_valid_next;
    logic signed [CMD_W-1:0] diff_reg;
    logic signed [CMD_W-1:0] diff_next;
    logic signed [CMD_W-1:0] sum_reg;
    logic signed [CMD_W-1:0] sum_next;
    logic        [CMD_W-1:0] diff_mag;
    logic                    accept;

    assign s_tready = !st_valid_reg || !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = st_valid_reg && !q_full;

    always_comb begin
        st_valid_next = st_valid_reg;
        diff_next     = diff_reg;
        sum_next      = sum_reg;
        if (q_push) begin
            st_valid_next = 1'b0;
        end
        if (accept) begin
            st_valid_next = 1'b1;
            if (run_enable) begin
                diff_next = CMD_W'(fwd_speed) - CMD_W'(yaw_term);
                sum_next  = CMD_W'(fwd_speed) + CMD_W'(yaw_term);
            end else begin
                diff_next = '0;
                sum_next  = '0;
            end
        end
    end

    assign diff_mag          = diff_reg[CMD_W-1] ? CMD_W'(-diff_reg) : CMD_W'(diff_reg);
    assign q_wdata.diff      = diff_reg;
    assign q_wdata.sum       = sum_reg;
    assign q_wdata.rear_full = FULL_W'(diff_mag) * FULL_W'(rear_gain_q8);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else begin
            st_valid_reg <= st_valid_next;
        end
        diff_reg <= diff_next;
        sum_reg  <= sum_next;
    end

endmodule

FILE: rtl/core/ssmm_fifo.sv
// Tick queue between the front and back ends.
module ssmm_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  ssmm_pkg::tick_t wdata,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output ssmm_pkg::tick_t head
);
    import ssmm_pkg::*;

    tick_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

FILE: rtl/core/ssmm_back.sv
// Back end: per-motor deadzone, limit, brake sequencing and output register.
module ssmm_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  ssmm_pkg::tick_t               q_head,
    output logic                          q_pop,
    input  logic [ssmm_pkg::DUTY_W-1:0]   deadzone,
    input  logic [ssmm_pkg::DUTY_W-1:0]   max_duty,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ssmm_pkg::out_item_t           out_item
);
    import ssmm_pkg::*;

    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    logic               brk_done_reg;
    logic               brk_done_next;
    dir_t               dir_reg  [N_MOTORS];
    dir_t               dir_next [N_MOTORS];
    logic               pin_reg  [N_MOTORS];
    logic               pin_next [N_MOTORS];
    logic               out_valid_reg;
    logic               out_valid_next;
    out_item_t          item_reg;
    out_item_t          item_next;

    logic [MOTOR_W-1:0] motor;
    logic               rear;
    logic [CMD_W-1:0]   cmd;
    logic               neg;
    logic [CMD_W-1:0]   mag;
    logic [SRC_W-1:0]   src;
    logic               in_dz;
    logic [DUTY_W-1:0]  lim;
    logic               stop;
    dir_t               want;
    dir_t               cur_dir;
    logic               need_brake;
    logic               out_free;
    logic               go;

    assign out_free  = !out_valid_reg || out_ready;
    assign go        = q_valid && out_free;
    assign out_valid = out_valid_reg;
    assign out_item  = item_reg;

    always_comb begin
        motor = motor_of_step(step_reg);
        rear  = (motor == MOTOR_REAR);
        cmd   = (motor == MOTOR_LEFT_F || motor == MOTOR_REAR) ? q_head.diff : q_head.sum;
        neg   = cmd[CMD_W-1];
        mag   = neg ? CMD_W'(-cmd) : cmd;
        if (rear) begin
            src   = q_head.rear_full[FULL_W-1:FRAC_W];
            in_dz = (q_head.rear_full <= FULL_W'({deadzone, {FRAC_W{1'b0}}}));
        end else begin
            src   = SRC_W'(mag);
            in_dz = (mag <= CMD_W'(deadzone));
        end
        lim        = (src > SRC_W'(max_duty)) ? max_duty : src[DUTY_W-1:0];
        stop       = in_dz || (lim == '0);
        want       = neg ? DIR_REV : DIR_FWD;
        cur_dir    = dir_reg[motor];
        need_brake = !stop && !brk_done_reg && cur_dir != want
                     && (cur_dir == DIR_FWD || cur_dir == DIR_REV);
    end

    always_comb begin
        step_next      = step_reg;
        brk_done_next  = brk_done_reg;
        dir_next       = dir_reg;
        pin_next       = pin_reg;
        out_valid_next = out_free ? go : out_valid_reg;
        q_pop          = 1'b0;

        item_next             = item_reg;
        item_next.motor_index = motor;
        item_next.fwd_duty    = '0;
        item_next.rev_duty    = '0;
        item_next.dir_pin     = pin_reg[motor];
        item_next.is_brake    = 1'b0;
        item_next.in_deadzone = 1'b0;
        item_next.last        = (step_reg == STEP_LAST) && !need_brake;

        if (stop) begin
            item_next.in_deadzone = in_dz;
        end else if (need_brake) begin
            item_next.is_brake = 1'b1;
        end else if (neg) begin
            item_next.rev_duty = lim;
            item_next.dir_pin  = 1'b0;
        end else begin
            item_next.fwd_duty = lim;
            item_next.dir_pin  = 1'b1;
        end

        if (go) begin
            if (need_brake) begin
                brk_done_next = 1'b1;
            end else begin
                brk_done_next = 1'b0;
                step_next     = step_reg + 1'b1;
                q_pop         = (step_reg == STEP_LAST);
                if (stop) begin
                    dir_next[motor] = DIR_STOP;
                end else begin
                    dir_next[motor] = want;
                    pin_next[motor] = !neg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= '0;
            brk_done_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < N_MOTORS; i++) begin
                dir_reg[i] <= DIR_STOP;
                pin_reg[i] <= 1'b0;
            end
        end else begin
            step_reg      <= step_next;
            brk_done_reg  <= brk_done_next;
            out_valid_reg <= out_valid_next;
            dir_reg       <= dir_next;
            pin_reg       <= pin_next;
        end
        if (go) begin
            item_reg <= item_next;
        end
    end

endmodule

FILE: rtl/core/skid_steer_motor_mixer.sv
// Top level of the skid-steer motor mixer: config registers, front, queue, back.
//
//  channel   dir   handshake            payload
//  s_        in    s_tvalid/s_tready    tdata speed+yaw, tuser run_enable
//  m_        out   m_tvalid/m_tready    tdata motor update, tuser flags, tlast
//  cfg_      in    cfg_wr_en            cfg_index, cfg_wdata
//
// A tick gives four to eight words in the back end: one per motor update and one per brake.
// The front end registers each tick before pushing it into the queue, which holds up to four ticks.
// Reset: deadzone 400, max_duty 2000, rear gain 333, every motor stopped, pins low.
// m_tready low holds the output register and the back end; the front fills the queue.
`include "skid_steer_motor_mixer_assert.svh"

module skid_steer_motor_mixer (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [ssmm_pkg::S_TDATA_W-1:0]       s_tdata,  // fwd_speed, yaw_term
    input  logic                                 s_tuser,  // run_enable
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [ssmm_pkg::M_TDATA_W-1:0]       m_tdata,  // motor_index, fwd_duty, rev_duty, dir_pin
    output logic [ssmm_pkg::M_TUSER_W-1:0]       m_tuser,  // is_brake, in_deadzone
    output logic                                 m_tlast,
    input  logic                                 cfg_wr_en,
    input  logic [ssmm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ssmm_pkg::DUTY_W-1:0]          cfg_wdata
);
    import ssmm_pkg::*;

    logic [DUTY_W-1:0] deadzone_reg;
    logic [DUTY_W-1:0] deadzone_next;
    logic [DUTY_W-1:0] max_duty_reg;
    logic [DUTY_W-1:0] max_duty_next;
    logic [GAIN_W-1:0] gain_reg;
    logic [GAIN_W-1:0] gain_next;

    logic              q_full;
    logic              q_push;
    tick_t             q_wdata;
    logic              q_pop;
    logic              q_valid;
    tick_t             q_head;
    out_item_t         out_item;

    always_comb begin
        deadzone_next = deadzone_reg;
        max_duty_next = max_duty_reg;
        gain_next     = gain_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_DEADZONE:  deadzone_next = cfg_wdata;
                CFG_MAX_DUTY:  max_duty_next = cfg_wdata;
                CFG_REAR_GAIN: gain_next     = cfg_wdata[GAIN_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadzone_reg <= DEADZONE_RST;
            max_duty_reg <= MAX_DUTY_RST;
            gain_reg     <= REAR_GAIN_RST;
        end else begin
            deadzone_reg <= deadzone_next;
            max_duty_reg <= max_duty_next;
            gain_reg     <= gain_next;
        end
    end

    ssmm_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .fwd_speed    (s_tdata[SPD_W-1:0]),
        .yaw_term     (s_tdata[2*SPD_W-1:SPD_W]),
        .run_enable   (s_tuser),
        .rear_gain_q8 (gain_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_wdata      (q_wdata)
    );

    ssmm_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .wdata      (q_wdata),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    ssmm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .deadzone  (deadzone_reg),
        .max_duty  (max_duty_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tdata = M_TDATA_W'({out_item.dir_pin, out_item.rev_duty,
                                 out_item.fwd_duty, out_item.motor_index});
    assign m_tuser = {out_item.in_deadzone, out_item.is_brake};
    assign m_tlast = out_item.last;

    `SSMM_ASSERT_SAME(a_brake_zero, aclk, aresetn, m_tvalid && out_item.is_brake, out_item.fwd_duty == '0 && out_item.rev_duty == '0 && !out_item.last, "brake word drives a compare or ends the tick")
    `SSMM_ASSERT_SAME(a_fwd_pin, aclk, aresetn, m_tvalid && out_item.fwd_duty != '0, out_item.dir_pin && out_item.rev_duty == '0 && !out_item.in_deadzone, "forward compare without forward pin")
    `SSMM_ASSERT_NEXT(a_brake_follow, aclk, aresetn, m_tvalid && m_tready && out_item.is_brake, m_tvalid && !out_item.is_brake && out_item.motor_index == $past(out_item.motor_index), "brake not followed by drive word of same motor")

endmodule

FILE: tb/skid_steer_motor_mixer_test.sv
// Self-checking testbench of the skid-steer motor mixer: directed script, then random ticks.
`timescale 1ns / 100ps

module skid_steer_motor_mixer_test;
    import ssmm_pkg::*;

    localparam int N_ROWS       = 34;
    localparam int RANDOM_TICKS = 69;
    localparam logic [CFG_IDX_W-1:0] NO_REG = 2'd3;
    localparam logic [MOTOR_W-1:0] SERVICE_ORDER [N_MOTORS] =
        '{MOTOR_LEFT_F, MOTOR_REAR, MOTOR_RIGHT_F, MOTOR_RIGHT_R};

    typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

    // Typed rows expect the same word on all four motors, with a brake word first if brk.
    typedef struct packed {
        row_kind_t          kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [DUTY_W-1:0]  reg_val;
        logic [SPD_W-1:0]   speed;
        logic [SPD_W-1:0]   yaw;
        logic               run;
        logic               typed;
        logic [DUTY_W-1:0]  duty;
        logic               pin;
        logic               brk;
        logic               dz;
    } script_row_t;

    localparam script_row_t SCRIPT [N_ROWS] = '{
        '{ROW_TICK, NO_REG, 15'd0, 16'h7FFF, 16'h8000, 1'b0, 1'b1, 15'd0, 1'b0, 1'b0, 1'b1},
        '{ROW_TICK, NO_REG, 15'd0, 16'h012C, 16'h0000, 1'b1, 1'b1, 15'd0, 1'b0, 1'b0, 1'b1},
        '{ROW_TICK, NO_REG, 15'd0, 16'h7FFF, 16'h0000, 1'b1, 1'b1, 15'd2000, 1'b1, 1'b0, 1'b0},
        '{ROW_TICK, NO_REG, 15'd0, 16'h8000, 16'h0000, 1'b1, 1'b1, 15'd2000, 1'b0, 1'b1, 1'b0},
        '{ROW_TICK, NO_REG, 15'd0, 16'h04D2, 16'h0000, 1'b0, 1'b1, 15'd0, 1'b0, 1'b0, 1'b1},
        '{ROW_TICK, NO_REG, 15'd0, 16'h7FFF, 16'h8000, 1'b1, 1'b0, 15'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_TICK, NO_REG, 15'd0, 16'h8000, 16'h7FFF, 1'b1, 1'b0, 15'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_TICK, NO_REG, 15'd0, 16'h8000, 16'h8000, 1'b1, 1'b0, 15'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_TICK, NO_REG, 15'd0, 16'h7FFF, 16'h7FFF, 1'b1, 1'b0, 15'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_TICK, NO_REG, 15'd0, 16'h0191, 16'h0000, 1'b1, 1'b0, 15'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_TICK, NO_REG, 15'd0, 16'h0000, 16'hFE6F, 1'b1, 1'b0, 15'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_TICK, NO_REG, 15'd0, 16'h0134, 16'h0000, 1'b1, 1'b0, 15'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG, CFG_DEADZONE, 15'd0, 16'h0, 16'h0, 1'b0, 1'b0, 15'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG, CFG_MAX_DUTY, 15'd32767, 16'h0, 16'h0, 1'b0, 1'b0, 15'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG, CFG_REAR_GAIN, 15'd1023, 16'h0, 16'h0, 1'b0, 1'b0, 15'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_TICK, NO_REG, 15'd0, 16'h7FFF, 16'h7FFF, 1'b1, 1'b0, 15'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_TICK, NO_REG, 15'd0, 16'h8000, 16'h8000, 1'b1, 1'b0, 15'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_TICK, NO_REG, 15'd0, 16'h7FFF, 16'h8000, 1'b1, 1'b0, 15'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_TICK, NO_REG, 15'd0, 16'h0001, 16'h0000, 1'b1, 1'b0, 15'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG, CFG_REAR_GAIN, 15'd1, 16'h0, 16'h0, 1'b0, 1'b0, 15'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_TICK, NO_REG, 15'd0, 16'h0001, 16'h0000, 1'b1, 1'b0, 15'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_TICK, NO_REG, 15'd0, 16'hFF01, 16'h0000, 1'b1, 1'b0, 15'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG, CFG_REAR_GAIN, 15'd0, 16'h0, 16'h0, 1'b0, 1'b0, 15'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_TICK, NO_REG, 15'd0, 16'h0005, 16'h0000, 1'b1, 1'b0, 15'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG, CFG_MAX_DUTY, 15'd0, 16'h0, 16'h0, 1'b0, 1'b0, 15'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_TICK, NO_REG, 15'd0, 16'h0064, 16'hFFCE, 1'b1, 1'b0, 15'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_TICK, NO_REG, 15'd0, 16'h0000, 16'h0000, 1'b1, 1'b0, 15'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG, CFG_DEADZONE, 15'd32767, 16'h0, 16'h0, 1'b0, 1'b0, 15'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG, CFG_MAX_DUTY, 15'd32767, 16'h0, 16'h0, 1'b0, 1'b0, 15'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG, CFG_REAR_GAIN, 15'd512, 16'h0, 16'h0, 1'b0, 1'b0, 15'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_TICK, NO_REG, 15'd0, 16'h7FFF, 16'h0000, 1'b1, 1'b0, 15'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_TICK, NO_REG, 15'd0, 16'h8000, 16'h0000, 1'b1, 1'b0, 15'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_TICK, NO_REG, 15'd0, 16'h7FFF, 16'h7FFF, 1'b1, 1'b0, 15'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_TICK, NO_REG, 15'd0, 16'h8000, 16'h8000, 1'b1, 1'b0, 15'd0, 1'b0, 1'b0, 1'b0}
    };

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;  // fwd_speed, yaw_term
    logic                   s_tuser   = 1'b0;  // run_enable
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;   // motor_index, fwd_duty, rev_duty, dir_pin
    logic [M_TUSER_W-1:0]   m_tuser;   // is_brake, in_deadzone
    logic                   m_tlast;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [DUTY_W-1:0]      cfg_wdata = '0;

    // predictor state
    logic [DUTY_W-1:0]      dead_zone    = DEADZONE_RST;
    logic [DUTY_W-1:0]      max_duty_lim = MAX_DUTY_RST;
    logic [GAIN_W-1:0]      rear_gain    = REAR_GAIN_RST;
    dir_t                   kept_dir [N_MOTORS];
    logic                   kept_pin [N_MOTORS];

    out_item_t              motor_updates_due [$];
    out_item_t              tick_updates [$];
    out_item_t              typed_updates [$];
    int                     mismatch_count = 0;
    int                     send_idle_pct  = 0;
    int                     recv_idle_pct  = 0;

    skid_steer_motor_mixer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #1000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic out_item_t make_word(input logic [MOTOR_W-1:0] m,
                                            input logic [DUTY_W-1:0] fwd, rev,
                                            input logic pin, brk, dz);
        out_item_t w;
        w.motor_index = m;
        w.fwd_duty    = fwd;
        w.rev_duty    = rev;
        w.dir_pin     = pin;
        w.is_brake    = brk;
        w.in_deadzone = dz;
        w.last        = 1'b0;
        return w;
    endfunction

    function automatic void drive_motor(input logic [MOTOR_W-1:0] m, input int cmd,
                                        input bit rear);
        bit     neg;
        bit     stop;
        bit     dz_hit;
        longint mag;
        longint full;
        neg    = cmd < 0;
        mag    = neg ? -longint'(cmd) : longint'(cmd);
        stop   = 1'b0;
        dz_hit = 1'b0;
        // rear motor compares the full Q8 product, then truncates
        if (rear) begin
            full = mag * longint'(rear_gain);
            if (full <= longint'(dead_zone) * 256) begin
                stop   = 1'b1;
                dz_hit = 1'b1;
            end else begin
                mag = full / 256;
            end
        end else if (mag <= longint'(dead_zone)) begin
            stop   = 1'b1;
            dz_hit = 1'b1;
        end
        if (!stop) begin
            if (mag > longint'(max_duty_lim))
                mag = longint'(max_duty_lim);
            if (mag == 0)
                stop = 1'b1;
        end
        if (stop) begin
            kept_dir[m] = DIR_STOP;
            tick_updates.push_back(make_word(m, 15'd0, 15'd0, kept_pin[m], 1'b0, dz_hit));
        end else begin
            if ((kept_dir[m] == DIR_FWD && neg) || (kept_dir[m] == DIR_REV && !neg))
                tick_updates.push_back(make_word(m, 15'd0, 15'd0, kept_pin[m], 1'b1, 1'b0));
            kept_pin[m] = !neg;
            if (neg)
                kept_dir[m] = DIR_REV;
            else
                kept_dir[m] = DIR_FWD;
            tick_updates.push_back(make_word(m, neg ? 15'd0 : mag[DUTY_W-1:0],
                                             neg ? mag[DUTY_W-1:0] : 15'd0,
                                             !neg, 1'b0, 1'b0));
        end
    endfunction

    function automatic void mix_tick(input logic signed [SPD_W-1:0] spd, yaw, input logic run);
        int s;
        int y;
        s = 0;
        y = 0;
        if (run) begin
            s = int'(spd);
            y = int'(yaw);
        end
        tick_updates.delete();
        drive_motor(MOTOR_LEFT_F, s - y, 1'b0);
        drive_motor(MOTOR_REAR, s - y, 1'b1);
        drive_motor(MOTOR_RIGHT_F, s + y, 1'b0);
        drive_motor(MOTOR_RIGHT_R, s + y, 1'b0);
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(negedge aclk)
        m_tready = ($urandom_range(99) >= recv_idle_pct);

    always @(posedge aclk) begin : watch_updates
        out_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (motor_updates_due.size() == 0) begin
                $error("unexpected word: tdata %h tuser %b tlast %b", m_tdata, m_tuser, m_tlast);
                mismatch_count++;
            end else begin
                want = motor_updates_due.pop_front();
                check_field("motor_index", want.motor_index, m_tdata[1:0]);
                check_field("fwd_duty", want.fwd_duty, m_tdata[16:2]);
                check_field("rev_duty", want.rev_duty, m_tdata[31:17]);
                check_field("dir_pin", want.dir_pin, m_tdata[32]);
                check_field("is_brake", want.is_brake, m_tuser[0]);
                check_field("in_deadzone", want.in_deadzone, m_tuser[1]);
                check_field("last", want.last, m_tlast);
            end
        end
    end

    // Entered and left at a falling edge; valid stays high for a back-to-back word.
    task automatic send_tick(input logic signed [SPD_W-1:0] spd, yaw, input logic run,
                             input bit typed);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {yaw, spd};
        s_tuser  = run;
        do @(posedge aclk); while (!s_tready);
        mix_tick(spd, yaw, run);
        if (typed)
            tick_updates = typed_updates;
        tick_updates[tick_updates.size() - 1].last = 1'b1;
        foreach (tick_updates[i])
            motor_updates_due.push_back(tick_updates[i]);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (motor_updates_due.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUTY_W-1:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            CFG_DEADZONE:  dead_zone    = val;
            CFG_MAX_DUTY:  max_duty_lim = val;
            CFG_REAR_GAIN: rear_gain    = val[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_random_tick();
        int                     span;
        logic signed [SPD_W-1:0] spd;
        logic signed [SPD_W-1:0] yaw;
        logic                   run;
        span = int'(dead_zone) + int'(max_duty_lim) + 64;
        if (span > 32767)
            span = 32767;
        if ($urandom_range(99) < 30) begin
            spd = 16'($urandom);
            yaw = 16'($urandom);
        end else begin
            // mostly near the deadzone and saturation edges
            spd = 16'(int'($urandom_range(0, 2 * span)) - span);
            yaw = 16'(int'($urandom_range(0, span)) - span / 2);
        end
        run = ($urandom_range(9) != 0);
        send_tick(spd, yaw, run, 1'b0);
    endtask

    initial begin : stimulus
        script_row_t row;
        foreach (kept_dir[m]) begin
            kept_dir[m] = DIR_STOP;
            kept_pin[m] = 1'b0;
        end
        send_idle_pct = 8;
        recv_idle_pct = 84;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        for (int r = 0; r < N_ROWS; r++) begin
            row = SCRIPT[r];
            if (row.kind == ROW_CFG) begin
                wait_idle();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                typed_updates.delete();
                if (row.typed) begin
                    foreach (SERVICE_ORDER[k]) begin
                        if (row.brk)
                            typed_updates.push_back(make_word(SERVICE_ORDER[k], 15'd0, 15'd0,
                                                              !row.pin, 1'b1, 1'b0));
                        typed_updates.push_back(make_word(SERVICE_ORDER[k],
                                                          row.pin ? row.duty : 15'd0,
                                                          row.pin ? 15'd0 : row.duty,
                                                          row.pin, 1'b0, row.dz));
                    end
                end
                send_tick(row.speed, row.yaw, row.run, row.typed);
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    send_idle_pct = 8;
                    recv_idle_pct = 84;
                    write_reg(CFG_DEADZONE, 15'($urandom_range(0, 600)));
                    write_reg(CFG_MAX_DUTY, 15'($urandom_range(300, 4000)));
                    write_reg(CFG_REAR_GAIN, 15'($urandom_range(0, 1023)));
                end
                1: begin
                    send_idle_pct = 84;
                    recv_idle_pct = 8;
                    write_reg(CFG_DEADZONE, 15'($urandom_range(0, 3000)));
                    write_reg(CFG_MAX_DUTY, 15'($urandom_range(0, 32767)));
                    write_reg(CFG_REAR_GAIN, 15'($urandom_range(0, 1023)));
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    write_reg(CFG_DEADZONE, DEADZONE_RST);
                    write_reg(CFG_MAX_DUTY, MAX_DUTY_RST);
                    write_reg(CFG_REAR_GAIN, 15'(REAR_GAIN_RST));
                end
            endcase
            for (int n = 0; n < RANDOM_TICKS; n++) begin
                // hold off until the mixer has drained
                if (n == RANDOM_TICKS / 2)
                    wait_idle();
                send_random_tick();
            end
        end

        s_tvalid = 1'b0;
        while (motor_updates_due.size() != 0)
            @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
